// ===== rtl/core/button_gesture_detector_top_assert.svh =====
// Assertion macros for the button gesture detector.
// Expects clk and rst in the scope where a macro is used.
`ifndef BUTTON_GESTURE_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bgd_pkg.sv =====
// Shared widths, reset values and register indexes of the button gesture detector.
// No dependencies.
package bgd_pkg;

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int TALLY_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] HOLD_TIME_RESET   = CFG_W'(500);
  localparam logic [CFG_W-1:0] DC_TIME_RESET     = CFG_W'(300);
  localparam logic [CFG_W-1:0] DC_TOL_RESET      = CFG_W'(150);

  localparam logic [TALLY_W-1:0] TALLY_NONE  = TALLY_W'(0);
  localparam logic [TALLY_W-1:0] TALLY_ONE   = TALLY_W'(1);
  localparam logic [TALLY_W-1:0] TALLY_TWO   = TALLY_W'(2);
  localparam logic [TALLY_W-1:0] TALLY_THREE = TALLY_W'(3);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_TIME = 2'd0,
    REG_DC_TIME   = 2'd1,
    REG_DC_TOL    = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/core/bgd_sample_if.sv =====
// Sample channel: one button level and timestamp per request.
// Depends on bgd_pkg.
interface bgd_sample_if;
  import bgd_pkg::*;

  logic              valid;
  logic              ready;
  logic              pressed;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output pressed, output now_ms, input ready);
  modport sink   (input valid, input pressed, input now_ms, output ready);
endinterface

// ===== rtl/core/bgd_gesture_if.sv =====
// Gesture channel: five event flags per request.
// No dependencies.
interface bgd_gesture_if;
  logic valid;
  logic ready;
  logic press_event;
  logic release_event;
  logic hold_event;
  logic click_event;
  logic double_click_event;

  modport source (output valid, output press_event, output release_event,
                  output hold_event, output click_event, output double_click_event,
                  input ready);
  modport sink   (input valid, input press_event, input release_event,
                  input hold_event, input click_event, input double_click_event,
                  output ready);
endinterface

// ===== rtl/core/button_gesture_detector_top.sv =====
// Button gesture detector: press, release, hold, click and double-click flags.
// Depends on bgd_pkg, bgd_sample_if, bgd_gesture_if and the assert macro header.
//
//   channel   direction  contents
//   sample    in         pressed, now_ms
//   gesture   out        press, release, hold, click, double_click events
//   cfg       in         cfg_we, cfg_index, cfg_data (hold, dc time, dc tolerance)
//
// One sample per cycle while the sink keeps up: the timer adds and compares sit
// between the state registers and the gesture output register, with no stage between.
// A sample is taken whenever the output register is empty or drains that cycle.
// rst is synchronous; it clears state, timers and output valid, and loads the
// configuration reset values.
`include "button_gesture_detector_top_assert.svh"

module button_gesture_detector_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]         cfg_data,
  bgd_sample_if.sink                        sample,
  bgd_gesture_if.source                     gesture
);
  import bgd_pkg::*;

  logic [CFG_W-1:0]   hold_time;
  logic [CFG_W-1:0]   dc_time;
  logic [CFG_W-1:0]   dc_tol;

  logic               prev_press;
  logic               prev_hold;
  logic [TIME_W-1:0]  hold_deadline;
  logic [TIME_W-1:0]  hold_deadline_next;
  logic [TALLY_W-1:0] click_tally;
  logic [TALLY_W-1:0] click_tally_next;
  logic [TIME_W-1:0]  dc_deadline;
  logic [TIME_W-1:0]  dc_deadline_next;

  logic               accept;
  logic               ev_press;
  logic               ev_release;
  logic               ev_hold;
  logic               ev_click;
  logic               ev_double;
  logic [TALLY_W-1:0] tally_inc;
  logic [TIME_W-1:0]  dist_raw;
  logic [TIME_W-1:0]  dist_abs;

  assign sample.ready = !gesture.valid || gesture.ready;
  assign accept       = sample.valid && sample.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_TIME_RESET;
      dc_time   <= DC_TIME_RESET;
      dc_tol    <= DC_TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_HOLD_TIME: hold_time <= cfg_data;
        REG_DC_TIME:   dc_time   <= cfg_data;
        REG_DC_TOL:    dc_tol    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign dist_raw = sample.now_ms - dc_deadline;
  assign dist_abs = dist_raw[TIME_W-1] ? (TIME_W'(0) - dist_raw) : dist_raw;
  assign tally_inc = click_tally + TALLY_ONE;

  always_comb begin
    ev_press           = sample.pressed;
    ev_release         = 1'b0;
    ev_hold            = 1'b0;
    ev_click           = 1'b0;
    ev_double          = 1'b0;
    hold_deadline_next = hold_deadline;
    click_tally_next   = click_tally;
    dc_deadline_next   = dc_deadline;

    if (sample.pressed) begin
      if (prev_hold) begin
        ev_hold = 1'b1;
      end else if (hold_deadline == '0) begin
        hold_deadline_next = sample.now_ms + TIME_W'(hold_time);
      end else if (sample.now_ms >= hold_deadline) begin
        ev_hold            = 1'b1;
        hold_deadline_next = '0;
      end
    end else if (prev_press) begin
      ev_release         = 1'b1;
      hold_deadline_next = '0;
      ev_click           = !prev_hold;
    end

    if (ev_click) begin
      click_tally_next = tally_inc;
      if (tally_inc == TALLY_ONE) begin
        dc_deadline_next = sample.now_ms + TIME_W'(dc_time);
      end else if (tally_inc == TALLY_TWO && dist_abs < TIME_W'(dc_tol)) begin
        ev_double        = 1'b1;
        click_tally_next = TALLY_NONE;
        dc_deadline_next = '0;
      end else if (tally_inc == TALLY_THREE ||
                   (dc_deadline != '0 && sample.now_ms > dc_deadline)) begin
        // third click or stale window: start over
        click_tally_next = TALLY_NONE;
        dc_deadline_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_press    <= 1'b0;
      prev_hold     <= 1'b0;
      hold_deadline <= '0;
      click_tally   <= TALLY_NONE;
      dc_deadline   <= '0;
    end else if (accept) begin
      prev_press    <= ev_press;
      prev_hold     <= ev_hold;
      hold_deadline <= hold_deadline_next;
      click_tally   <= click_tally_next;
      dc_deadline   <= dc_deadline_next;
    end
  end

  // Output register: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      gesture.valid <= 1'b0;
    end else if (accept) begin
      gesture.valid <= 1'b1;
    end else if (gesture.ready) begin
      gesture.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gesture.press_event        <= ev_press;
      gesture.release_event      <= ev_release;
      gesture.hold_event         <= ev_hold;
      gesture.click_event        <= ev_click;
      gesture.double_click_event <= ev_double;
    end
  end

  `BGD_ASSERT_NOW(a_tally_never_three, 1'b1, click_tally != TALLY_THREE,
                  "click tally reached three")
  `BGD_ASSERT_NEXT(a_release_stops_hold, accept && !sample.pressed,
                   hold_deadline == '0, "hold timer running after release")
  `BGD_ASSERT_NEXT(a_double_clears, accept && ev_double,
                   click_tally == TALLY_NONE && dc_deadline == '0,
                   "double-click left tally or deadline set")
  `BGD_ASSERT_NOW(a_double_is_click, gesture.valid && gesture.double_click_event,
                  gesture.click_event && gesture.release_event,
                  "double-click flag without click")
  `BGD_ASSERT_NOW(a_hold_needs_press, gesture.valid && gesture.hold_event,
                  gesture.press_event, "hold flag without press")

endmodule
